// ===== design/sfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfrc_pkg
// Types, constants and the CRC-16 byte update for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package sfrc_pkg;

   localparam int MSG_BYTES = 16;
   localparam int ADDR_W    = (MSG_BYTES > 2) ? $clog2(MSG_BYTES) : 1;
   localparam int POS_W     = $clog2(MSG_BYTES + 2);
   localparam int IDX_W     = 4;
   localparam int CMP_W     = POS_W + IDX_W;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   localparam logic [2:0] CSR_SYNC     = 3'd0;
   localparam logic [2:0] CSR_ESCAPE   = 3'd1;
   localparam logic [2:0] CSR_ESC_MASK = 3'd2;
   localparam logic [2:0] CSR_LEN_MASK = 3'd3;
   localparam logic [2:0] CSR_LEN_CODE = 3'd4;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_ACCEPT   = 3'd1;
   localparam logic [2:0] EV_COLL     = 3'd2;
   localparam logic [2:0] EV_OVERFLOW = 3'd3;
   localparam logic [2:0] EV_LENGTH   = 3'd4;

   localparam logic [1:0] CHK_IDLE = 2'd0;
   localparam logic [1:0] CHK_OWN  = 2'd1;
   localparam logic [1:0] CHK_COLL = 2'd2;

   typedef enum logic [2:0] {
      OP_RX      = 3'd0,
      OP_RELEASE = 3'd1,
      OP_LOAD_TX = 3'd2,
      OP_BEGIN   = 3'd3,
      OP_END     = 3'd4,
      OP_READ    = 3'd5,
      OP_TIMEOUT = 3'd6,
      OP_NONE    = 3'd7
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [7:0]        data;
      logic              idx_ok;
      logic [ADDR_W-1:0] addr;
   } item_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== design/sfrc_front.sv =====
// ----------------------------------------------------------------------------
// sfrc_front
// Accepts request transfers, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sfrc_front import sfrc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_operation,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic [IDX_W-1:0] req_byte_index,
   output logic                  head_valid,
   output item_type              head_item,
   input  wire logic             head_pop
);

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item;
   logic [CMP_W-1:0] idx_ext;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      idx_ext     = CMP_W'(req_byte_index);
      item.op     = op_type'(req_operation);
      item.data   = req_data_byte;
      item.idx_ok = idx_ext < CMP_W'(MSG_BYTES);
      item.addr   = idx_ext[ADDR_W-1:0];
      wr_ptr_in   = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in   = head_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in    = count_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

// ===== design/sfrc_back.sv =====
// ----------------------------------------------------------------------------
// sfrc_back
// Executes queued items against the frame state and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none
module sfrc_back import sfrc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        head_valid,
   input  wire item_type    head_item,
   output logic             head_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic [2:0]       rsp_event_res,
   output logic             rsp_message_ready,
   output logic [1:0]       rsp_check_status,
   output logic             rsp_collision_lamp,
   output logic [15:0]      rsp_frames_received,
   output logic [15:0]      rsp_collisions,
   output logic [15:0]      rsp_overflows
);

   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(MSG_BYTES - 1);

   logic [7:0] sync_ff, esc_ff, esc_mask_ff, len_mask_ff, len_code_ff;

   logic [7:0] rx_store [MSG_BYTES];
   logic [7:0] tx_store [MSG_BYTES];

   logic             in_frame_ff, in_frame_in, esc_pend_ff, esc_pend_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      rcrc_ff, rcrc_in, run_crc_ff, run_crc_in, tx_crc_ff, tx_crc_in;
   logic             ready_ff, ready_in, lamp_ff, lamp_in;
   logic [1:0]       chk_ff, chk_in;
   logic [15:0]      good_ff, good_in, coll_ff, coll_in, ovf_ff, ovf_in;
   logic             sweep_ff, sweep_in;
   logic [ADDR_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [15:0]      sweep_crc_ff, sweep_crc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rd_ff, rd_in;
   logic [2:0]       ev_ff, ev_in;

   logic              out_free, exec, finish, load_out, rx_wr, tx_wr;
   logic [7:0]        c;
   logic [15:0]       r;
   logic [ADDR_W-1:0] tx_addr;
   logic [7:0]        tx_byte;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign exec     = head_valid && !sweep_ff && out_free;
   assign finish   = sweep_ff && (sweep_cnt_ff == LAST) && out_free;
   assign head_pop = exec;
   assign tx_addr  = sweep_ff ? sweep_cnt_ff : pos_ff[ADDR_W-1:0];
   assign tx_byte  = tx_store[tx_addr];

   always_comb begin
      in_frame_in  = in_frame_ff;
      esc_pend_in  = esc_pend_ff;
      pos_in       = pos_ff;
      rcrc_in      = rcrc_ff;
      run_crc_in   = run_crc_ff;
      tx_crc_in    = tx_crc_ff;
      ready_in     = ready_ff;
      lamp_in      = lamp_ff;
      chk_in       = chk_ff;
      good_in      = good_ff;
      coll_in      = coll_ff;
      ovf_in       = ovf_ff;
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      sweep_crc_in = sweep_crc_ff;
      rd_in        = 8'h00;
      ev_in        = EV_NONE;
      load_out     = 1'b0;
      rx_wr        = 1'b0;
      tx_wr        = 1'b0;
      c            = head_item.data;
      r            = rcrc_ff | {8'h00, c};

      if (sweep_ff) begin
         sweep_crc_in = crc_byte(sweep_crc_ff, tx_byte);
         if (sweep_cnt_ff != LAST) begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
         end else if (finish) begin
            sweep_in  = 1'b0;
            tx_crc_in = sweep_crc_in;
            chk_in    = CHK_OWN;
            load_out  = 1'b1;
         end else begin
            sweep_crc_in = sweep_crc_ff;
         end
      end else if (exec) begin
         load_out = (head_item.op != OP_BEGIN);
         unique case (head_item.op)
            OP_RX: begin
               if (c == sync_ff) begin
                  if (in_frame_ff) begin
                     if (chk_ff != CHK_IDLE) chk_in = CHK_COLL;
                     lamp_in = 1'b1; coll_in = coll_ff + 1'b1;
                     in_frame_in = 1'b0; ev_in = EV_COLL;
                  end else begin
                     in_frame_in = 1'b1; pos_in = '0;
                     esc_pend_in = 1'b0; run_crc_in = CRC_INIT;
                  end
               end else if (!in_frame_ff) begin
                  ev_in = EV_NONE;
               end else if (ready_ff && chk_ff == CHK_IDLE) begin
                  in_frame_in = 1'b0; ovf_in = ovf_ff + 1'b1; ev_in = EV_OVERFLOW;
               end else if (c == esc_ff && !esc_pend_ff) begin
                  esc_pend_in = 1'b1;
               end else begin
                  if (esc_pend_ff) begin
                     esc_pend_in = 1'b0;
                     c = c ^ esc_mask_ff;
                  end
                  r = rcrc_ff | {8'h00, c};
                  if (chk_ff != CHK_IDLE) begin
                     if (pos_ff < POS_W'(MSG_BYTES)) begin
                        if (tx_byte != c) begin
                           chk_in = CHK_COLL; pos_in = '0;
                           lamp_in = 1'b1; coll_in = coll_ff + 1'b1;
                           in_frame_in = 1'b0; ev_in = EV_COLL;
                        end else begin
                           pos_in = pos_ff + 1'b1;
                        end
                     end else if (pos_ff == POS_W'(MSG_BYTES)) begin
                        rcrc_in = {c, 8'h00}; pos_in = pos_ff + 1'b1;
                     end else begin
                        rcrc_in = r;
                        if (r != tx_crc_ff) begin
                           chk_in = CHK_COLL; pos_in = '0;
                           lamp_in = 1'b1; coll_in = coll_ff + 1'b1;
                           in_frame_in = 1'b0; ev_in = EV_COLL;
                        end else begin
                           in_frame_in = 1'b0;
                           if (chk_ff == CHK_OWN) chk_in = CHK_IDLE;
                        end
                     end
                  end else if (pos_ff == '0 && (c & len_mask_ff) != len_code_ff) begin
                     lamp_in = 1'b0; in_frame_in = 1'b0; ev_in = EV_LENGTH;
                  end else if (pos_ff < POS_W'(MSG_BYTES)) begin
                     rx_wr = 1'b1;
                     run_crc_in = crc_byte(run_crc_ff, c);
                     pos_in = pos_ff + 1'b1;
                  end else if (pos_ff == POS_W'(MSG_BYTES)) begin
                     rcrc_in = {c, 8'h00}; pos_in = pos_ff + 1'b1;
                  end else begin
                     rcrc_in = r; in_frame_in = 1'b0;
                     if (r != run_crc_ff) begin
                        lamp_in = 1'b1; coll_in = coll_ff + 1'b1; ev_in = EV_COLL;
                     end else begin
                        good_in = good_ff + 1'b1; lamp_in = 1'b0;
                        ready_in = 1'b1; ev_in = EV_ACCEPT;
                     end
                  end
               end
            end
            OP_RELEASE: ready_in = 1'b0;
            OP_LOAD_TX: tx_wr = head_item.idx_ok;
            OP_BEGIN: begin
               sweep_in = 1'b1; sweep_cnt_in = '0; sweep_crc_in = CRC_INIT;
            end
            OP_END: begin
               chk_in = CHK_IDLE; lamp_in = 1'b0;
            end
            OP_READ: rd_in = head_item.idx_ok ? rx_store[head_item.addr] : 8'h00;
            OP_TIMEOUT: if (chk_ff == CHK_OWN) chk_in = CHK_COLL;
            OP_NONE: ev_in = EV_NONE;
            default: ev_in = EV_NONE;
         endcase
      end
      rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= 8'd126; esc_ff <= 8'd125; esc_mask_ff <= 8'd32;
         len_mask_ff <= 8'd192; len_code_ff <= 8'd64;
         in_frame_ff <= 1'b0; esc_pend_ff <= 1'b0; pos_ff <= '0;
         rcrc_ff <= 16'h0000; run_crc_ff <= CRC_INIT; tx_crc_ff <= CRC_INIT;
         ready_ff <= 1'b0; lamp_ff <= 1'b0; chk_ff <= CHK_IDLE;
         good_ff <= 16'h0000; coll_ff <= 16'h0000; ovf_ff <= 16'h0000;
         sweep_ff <= 1'b0; sweep_cnt_ff <= '0; sweep_crc_ff <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_SYNC:     sync_ff     <= csr_wdata;
               CSR_ESCAPE:   esc_ff      <= csr_wdata;
               CSR_ESC_MASK: esc_mask_ff <= csr_wdata;
               CSR_LEN_MASK: len_mask_ff <= csr_wdata;
               CSR_LEN_CODE: len_code_ff <= csr_wdata;
               default: ;
            endcase
         end
         in_frame_ff <= in_frame_in; esc_pend_ff <= esc_pend_in; pos_ff <= pos_in;
         rcrc_ff <= rcrc_in; run_crc_ff <= run_crc_in; tx_crc_ff <= tx_crc_in;
         ready_ff <= ready_in; lamp_ff <= lamp_in; chk_ff <= chk_in;
         good_ff <= good_in; coll_ff <= coll_in; ovf_ff <= ovf_in;
         sweep_ff <= sweep_in; sweep_cnt_ff <= sweep_cnt_in; sweep_crc_ff <= sweep_crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rd_ff <= rd_in;
         ev_ff <= ev_in;
      end
      if (rx_wr) rx_store[pos_ff[ADDR_W-1:0]] <= c;
      if (tx_wr) tx_store[head_item.addr] <= head_item.data;
   end

   // status fields track live state; it only changes when a new response loads
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rd_ff;
   assign rsp_event_res       = ev_ff;
   assign rsp_message_ready   = ready_ff;
   assign rsp_check_status    = chk_ff;
   assign rsp_collision_lamp  = lamp_ff;
   assign rsp_frames_received = good_ff;
   assign rsp_collisions      = coll_ff;
   assign rsp_overflows       = ovf_ff;

endmodule
`default_nettype wire

// ===== design/stuffed_frame_receiver_crc_check_unit.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_crc_check_unit
// Byte-stuffed frame receiver with CRC-16 check and own-send collision check.
// ----------------------------------------------------------------------------
// Request channel (req_*): one operation per transfer: rx byte, release,
//   load tx byte, begin self check, end check, read rx, check timeout.
// Response channel (rsp_*): exactly one response per request, in order,
//   carrying read data, the event code and the current status and counters.
// CSR port: write-only, taken on any cycle with csr_write high; write only
//   while the block is idle.
// Flow: a request is written into the queue on its transfer, then moves
//   from the queue head into the response register. Throughput is one
//   request per cycle while rsp_stall is low; begin self check holds the
//   back end for a sweep of every stored transmit byte through the CRC unit.
// A two-entry queue separates decode from execution. When the response side
//   stalls, the response register holds, the queue fills and req_stall rises.
// Reset (synchronous) clears frame state, counters and CSRs to their defaults;
//   message stores stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module stuffed_frame_receiver_crc_check_unit import sfrc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_index,
   input  wire logic [7:0]       csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_operation,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic [IDX_W-1:0] req_byte_index,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_read_data,
   output logic [2:0]            rsp_event_res,
   output logic                  rsp_message_ready,
   output logic [1:0]            rsp_check_status,
   output logic                  rsp_collision_lamp,
   output logic [15:0]           rsp_frames_received,
   output logic [15:0]           rsp_collisions,
   output logic [15:0]           rsp_overflows
);

   logic     head_valid, head_pop;
   item_type head_item;

   sfrc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_data_byte,
      .req_byte_index, .head_valid, .head_item, .head_pop
   );

   sfrc_back u_back (
      .clock, .reset, .csr_write, .csr_index, .csr_wdata,
      .head_valid, .head_item, .head_pop,
      .rsp_valid, .rsp_stall, .rsp_read_data, .rsp_event_res, .rsp_message_ready,
      .rsp_check_status, .rsp_collision_lamp, .rsp_frames_received,
      .rsp_collisions, .rsp_overflows
   );

`ifndef ASSERT_OFF
   a_accept_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_ACCEPT |-> rsp_message_ready)
      else $error("frame accepted without message ready");
   a_coll_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_COLL |-> rsp_collision_lamp)
      else $error("collision reported with lamp off");
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= EV_LENGTH)
      else $error("event code out of range");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_check_status != 2'd3)
      else $error("check status out of range");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stuffed frame receiver. Builds stuffed frames,
// own-send check sequences and random noise, predicts every response in a
// scoreboard and compares every field of it, with random bursts and stalls.
// ----------------------------------------------------------------------------
module testbench;
   import sfrc_pkg::*;

   typedef logic [7:0] msg_type [MSG_BYTES];

   typedef struct packed {
      logic [7:0]  rd;
      logic [2:0]  ev;
      logic        ready;
      logic [1:0]  chk;
      logic        lamp;
      logic [15:0] good;
      logic [15:0] coll;
      logic [15:0] ovf;
   } status_type;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      return c;
   endfunction

   class frame_scoreboard;
      logic [7:0]  syncb, escb, emask, lmask, lcode;
      bit          in_frame, esc_pend, ready, lamp;
      int          pos;
      logic [15:0] rcv_crc, run_crc, tx_crc;
      logic [1:0]  chk;
      msg_type     rx_store, tx_store;
      bit          rx_written [MSG_BYTES];
      logic [15:0] good, coll, ovf;
      status_type  pending [$];
      int          errors;

      function new();
         syncb = 126; escb = 125; emask = 32; lmask = 192; lcode = 64;
         run_crc = CRC_INIT; tx_crc = CRC_INIT; rcv_crc = 0; chk = CHK_IDLE;
         pos = 0; good = 0; coll = 0; ovf = 0; errors = 0;
         foreach (rx_written[i]) rx_written[i] = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [7:0] v);
         case (idx)
            CSR_SYNC:     syncb = v;
            CSR_ESCAPE:   escb = v;
            CSR_ESC_MASK: emask = v;
            CSR_LEN_MASK: lmask = v;
            CSR_LEN_CODE: lcode = v;
            default: ;
         endcase
      endfunction

      function logic [2:0] collide();
         lamp = 1; coll++; in_frame = 0;
         return EV_COLL;
      endfunction

      function logic [2:0] take_rx(logic [7:0] raw);
         logic [7:0] c;
         c = raw;
         if (c == syncb) begin
            if (in_frame) begin
               if (chk != CHK_IDLE) chk = CHK_COLL;
               return collide();
            end
            in_frame = 1; pos = 0; esc_pend = 0; run_crc = CRC_INIT;
            return EV_NONE;
         end
         if (!in_frame) return EV_NONE;
         if (ready && chk == CHK_IDLE) begin
            in_frame = 0; ovf++;
            return EV_OVERFLOW;
         end
         if (c == escb && !esc_pend) begin
            esc_pend = 1;
            return EV_NONE;
         end
         if (esc_pend) begin
            esc_pend = 0; c = c ^ emask;
         end
         if (chk != CHK_IDLE) begin
            if (pos < MSG_BYTES) begin
               if (tx_store[pos] != c) begin
                  chk = CHK_COLL; pos = 0;
                  return collide();
               end
               pos++;
            end else if (pos == MSG_BYTES) begin
               rcv_crc = {c, 8'h00}; pos++;
            end else begin
               rcv_crc = rcv_crc | {8'h00, c};
               if (rcv_crc != tx_crc) begin
                  chk = CHK_COLL; pos = 0;
                  return collide();
               end
               in_frame = 0;
               if (chk == CHK_OWN) chk = CHK_IDLE;
            end
            return EV_NONE;
         end
         if (pos == 0 && (c & lmask) != lcode) begin
            lamp = 0; in_frame = 0;
            return EV_LENGTH;
         end
         if (pos < MSG_BYTES) begin
            rx_store[pos] = c; rx_written[pos] = 1; pos++;
            run_crc = crc16_step(run_crc, c);
            return EV_NONE;
         end
         if (pos == MSG_BYTES) begin
            rcv_crc = {c, 8'h00}; pos++;
            return EV_NONE;
         end
         rcv_crc = rcv_crc | {8'h00, c};
         in_frame = 0;
         if (rcv_crc != run_crc) return collide();
         good++; lamp = 0; ready = 1;
         return EV_ACCEPT;
      endfunction

      function void note_request(op_type op, logic [7:0] data, logic [3:0] idx);
         status_type s;
         s.rd = 0; s.ev = EV_NONE;
         case (op)
            OP_RX:      s.ev = take_rx(data);
            OP_RELEASE: ready = 0;
            OP_LOAD_TX: tx_store[idx] = data;
            OP_BEGIN: begin
               chk = CHK_OWN; tx_crc = CRC_INIT;
               for (int k = 0; k < MSG_BYTES; k++) tx_crc = crc16_step(tx_crc, tx_store[k]);
            end
            OP_END: begin
               chk = CHK_IDLE; lamp = 0;
            end
            OP_READ:    s.rd = rx_store[idx];
            OP_TIMEOUT: if (chk == CHK_OWN) chk = CHK_COLL;
            default: ;
         endcase
         s.ready = ready; s.chk = chk; s.lamp = lamp;
         s.good = good; s.coll = coll; s.ovf = ovf;
         pending.push_back(s);
      endfunction

      function void check_response(status_type got);
         status_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [7:0]  csr_wdata;
   logic        req_valid, req_stall;
   logic [2:0]  req_operation;
   logic [7:0]  req_data_byte;
   logic [3:0]  req_byte_index;
   logic        rsp_valid, rsp_stall;
   logic [7:0]  rsp_read_data;
   logic [2:0]  rsp_event_res;
   logic        rsp_message_ready;
   logic [1:0]  rsp_check_status;
   logic        rsp_collision_lamp;
   logic [15:0] rsp_frames_received, rsp_collisions, rsp_overflows;

   frame_scoreboard sb;
   int burst_left;
   int items_sent;
   int idle_cycles;

   stuffed_frame_receiver_crc_check_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_data_byte(req_data_byte),
      .req_byte_index(req_byte_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data), .rsp_event_res(rsp_event_res),
      .rsp_message_ready(rsp_message_ready), .rsp_check_status(rsp_check_status),
      .rsp_collision_lamp(rsp_collision_lamp),
      .rsp_frames_received(rsp_frames_received), .rsp_collisions(rsp_collisions),
      .rsp_overflows(rsp_overflows)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(op_type op, logic [7:0] data, logic [3:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1;
      req_operation <= op;
      req_data_byte <= data;
      req_byte_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, data, idx);
      items_sent++;
      burst_left--;
   endtask

   task automatic send_rx(logic [7:0] b);
      send_item(OP_RX, b, 4'($urandom));
   endtask

   task automatic send_stuffed(logic [7:0] b);
      if (b == sb.syncb || b == sb.escb) begin
         send_rx(sb.escb);
         send_rx(b ^ sb.emask);
      end else begin
         send_rx(b);
      end
   endtask

   // fault: 0 clean, 1 payload bit flipped, 2 CRC bit flipped, 3 sync inside, 4 cut short
   task automatic send_frame(msg_type pl, int fault);
      logic [15:0] crc;
      int          at;
      crc = CRC_INIT;
      for (int k = 0; k < MSG_BYTES; k++) crc = crc16_step(crc, pl[k]);
      at = $urandom_range(0, MSG_BYTES - 1);
      if (fault == 1) pl[at] = pl[at] ^ 8'(1 << $urandom_range(0, 7));
      if (fault == 2) crc = crc ^ 16'(1 << $urandom_range(0, 15));
      send_rx(sb.syncb);
      for (int k = 0; k < MSG_BYTES; k++) begin
         if (fault == 4 && k == at) return;
         if (fault == 3 && k == at) send_rx(sb.syncb);
         send_stuffed(pl[k]);
      end
      send_stuffed(crc[15:8]);
      send_stuffed(crc[7:0]);
   endtask

   function automatic msg_type make_payload();
      msg_type p;
      foreach (p[k]) p[k] = 8'($urandom);
      p[0] = (p[0] & ~sb.lmask) | (sb.lcode & sb.lmask);
      return p;
   endfunction

   task automatic settle();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_regs(logic [7:0] s, logic [7:0] e, logic [7:0] m,
                           logic [7:0] lm, logic [7:0] lc);
      logic [7:0] v [5];
      v = '{s, e, m, lm, lc};
      for (int i = 0; i < 5; i++) begin
         @(posedge clock);
         csr_write <= 1;
         csr_index <= 3'(i);
         csr_wdata <= v[i];
         sb.write_reg(3'(i), v[i]);
      end
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic read_some();
      logic [3:0] i;
      repeat ($urandom_range(1, 3)) begin
         i = 4'($urandom);
         if (sb.rx_written[i]) send_item(OP_READ, 8'($urandom), i);
      end
   endtask

   task automatic own_check(int fault);
      repeat ($urandom_range(0, 3))
         send_item(OP_LOAD_TX, 8'($urandom), 4'($urandom));
      send_item(OP_BEGIN, 8'($urandom), 4'($urandom));
      send_frame(sb.tx_store, fault);
      if ($urandom_range(0, 2) == 0) send_item(OP_TIMEOUT, 8'($urandom), 4'($urandom));
      send_item(OP_END, 8'($urandom), 4'($urandom));
   endtask

   task automatic random_traffic(int target);
      int       r;
      int       f;
      op_type   op;
      logic [3:0] i;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         f = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 4);
         if (r < 45) begin
            send_frame(make_payload(), f);
            if ($urandom_range(0, 9) < 7) send_item(OP_RELEASE, 8'($urandom), 4'($urandom));
            if ($urandom_range(0, 1)) read_some();
         end else if (r < 60) begin
            own_check(f);
         end else if (r < 68) begin
            read_some();
         end else begin
            op = op_type'($urandom_range(0, 7));
            i = 4'($urandom);
            if (op == OP_READ && !sb.rx_written[i]) op = OP_NONE;
            send_item(op, 8'($urandom), i);
         end
      end
   endtask

   // receiver: stall pattern in segments of a randomly chosen mode, plus one long hold-off
   initial begin
      int mode;
      int seg;
      int cyc;
      rsp_stall = 0;
      mode = 0; seg = 0; cyc = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check_response({rsp_read_data, rsp_event_res, rsp_message_ready,
                               rsp_check_status, rsp_collision_lamp,
                               rsp_frames_received, rsp_collisions, rsp_overflows});
         cyc++;
         if (cyc == 3000) begin
            rsp_stall <= 1;
            seg = 400;
            mode = 3;
         end else begin
            if (seg == 0) begin
               mode = $urandom_range(0, 2);
               seg = 64;
            end
            seg--;
            case (mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= 1;
            endcase
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= 3000) begin
            $display("[stuffed_frame_receiver_crc_check_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      msg_type p;
      sb = new();
      reset = 1;
      csr_write = 0; csr_index = 0; csr_wdata = 0;
      req_valid = 0; req_operation = 0; req_data_byte = 0; req_byte_index = 0;
      burst_left = 0; items_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      settle();
      set_regs(8'd126, 8'd125, 8'd32, 8'd192, 8'd64);

      // directed
      for (int k = 0; k < MSG_BYTES; k++)
         send_item(OP_LOAD_TX, (k == 0) ? 8'h40 : (k == 1) ? 8'hFF : (k == 2) ? 8'h7E :
                   (k == 3) ? 8'h7D : 8'(k * 37), 4'(k));
      p = make_payload();
      p[1] = 8'h7E; p[2] = 8'h7D; p[3] = 8'h00; p[4] = 8'hFF;
      send_frame(p, 0);
      send_item(OP_READ, 8'hFF, 4'd0);
      send_item(OP_READ, 8'h00, 4'd15);
      send_frame(make_payload(), 0);
      send_item(OP_RELEASE, 8'h00, 4'd0);
      p = make_payload();
      p[0] = ~p[0];
      send_frame(p, 0);
      send_frame(make_payload(), 3);
      send_frame(make_payload(), 2);
      own_check(0);
      own_check(1);
      send_item(OP_BEGIN, 8'h00, 4'd0);
      send_item(OP_TIMEOUT, 8'h00, 4'd0);
      send_item(OP_END, 8'h00, 4'd0);
      send_item(OP_NONE, 8'hFF, 4'hF);

      random_traffic(425);
      settle();
      set_regs(8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
      random_traffic(850);
      settle();
      set_regs(8'd255, 8'd0, 8'd1, 8'd255, 8'hA5);
      random_traffic(1275);
      settle();
      begin
         logic [7:0] s, e, lm;
         s = 8'($urandom);
         e = s ^ 8'($urandom_range(1, 255));
         lm = 8'($urandom);
         set_regs(s, e, 8'($urandom_range(1, 255)), lm, 8'($urandom) & lm);
      end
      random_traffic(1700);

      settle();
      if (sb.errors == 0)
         $display("[stuffed_frame_receiver_crc_check_unit] OK");
      else
         $display("[stuffed_frame_receiver_crc_check_unit] ERROR");
      $finish;
   end

endmodule
